### design/dfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfa_pkg
// shared types and constants for the delimited frame assembler
// ----------------------------------------------------------------------------
package dfa_pkg;

    localparam int FRAME_DEPTH_DEFAULT = 64;

    localparam logic [7:0] CR_BYTE           = 8'h0D;
    localparam logic [7:0] DELIMITER_RESET   = 8'h0A;
    localparam logic [6:0] MAX_LENGTH_RESET  = 7'd64;

    localparam int PADDR_W = 3;

    typedef enum logic
    {
        REG_DELIMITER  = 1'b0,
        REG_MAX_LENGTH = 1'b1
    } reg_index_t;

    typedef enum logic
    {
        OP_BYTE  = 1'b0,
        OP_FLUSH = 1'b1
    } op_t;

    typedef enum logic
    {
        ST_ACCEPT = 1'b0,
        ST_DRAIN  = 1'b1
    } state_t;

endpackage

### design/delimited_frame_assembler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_frame_assembler
// gathers received bytes into frames and replays each finished frame
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while in_ready is high and written into a
// single-port frame memory of FRAME_DEPTH bytes. A frame ends at the
// delimiter register value or at a carriage return; a non-empty frame is
// then read back from the memory and sent out one byte per transfer, the
// final byte marked by last_byte, with the completed and oversize frame
// counts alongside. While a frame is read out, in_ready is low: each byte
// is a memory read, then an output register load, and the next read waits
// for a free output. A frame that would grow past min(max_frame_length,
// FRAME_DEPTH) bytes is dropped and counted, and bytes are discarded up to
// the next ending byte. A flush item clears the partial frame and the
// discard state; counters are kept. Registers: delimiter_byte at byte
// address 0, max_frame_length at byte address 4.
// ----------------------------------------------------------------------------
module delimited_frame_assembler
#(
    parameter int FRAME_DEPTH = dfa_pkg::FRAME_DEPTH_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dfa_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        op,
    input  logic [7:0]                  data_byte,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  frame_byte,
    output logic                        last_byte,
    output logic [31:0]                 frames_done,
    output logic [31:0]                 oversize_drops
);

    import dfa_pkg::*;

    localparam int AW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int LW = $clog2(FRAME_DEPTH + 1);

    logic [7:0]    mem [FRAME_DEPTH];

    logic [7:0]    delimiter_reg;
    logic [6:0]    max_length_reg;

    state_t        state_reg, state_next;
    logic [LW-1:0] len_reg;
    logic          discarding_reg;
    logic [31:0]   frame_count_reg;
    logic [31:0]   oversize_count_reg;
    logic [LW-1:0] drain_len_reg;
    logic [AW-1:0] rd_idx_reg;
    logic          rd_pend_reg;
    logic          rd_last_reg;
    logic [7:0]    rd_data_reg;

    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          out_last_reg;
    logic [31:0]   out_frames_reg;
    logic [31:0]   out_oversize_reg;

    logic          cfg_write;
    logic          in_xfer;
    logic          is_end;
    logic [6:0]    limit;
    logic          fits;
    logic          rd_issue;
    logic          rd_is_last;
    logic          start_drain;
    logic          store_byte;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (reg_index_t'(paddr[2]))
            REG_DELIMITER:  prdata = {24'd0, delimiter_reg};
            REG_MAX_LENGTH: prdata = {25'd0, max_length_reg};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter_reg  <= DELIMITER_RESET;
            max_length_reg <= MAX_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_index_t'(paddr[2]))
                REG_DELIMITER:  delimiter_reg  <= pwdata[7:0];
                REG_MAX_LENGTH: max_length_reg <= pwdata[6:0];
                default:        ;
            endcase
        end
    end

    // input decode
    assign in_xfer = in_valid && in_ready;
    assign is_end  = (data_byte == delimiter_reg) || (data_byte == CR_BYTE);
    assign limit   = (max_length_reg > 7'(FRAME_DEPTH)) ? 7'(FRAME_DEPTH) : max_length_reg;
    assign fits    = 7'(len_reg) < limit;

    assign start_drain = in_xfer && (op_t'(op) == OP_BYTE) && is_end
                         && !discarding_reg && (len_reg != '0);
    assign store_byte  = in_xfer && (op_t'(op) == OP_BYTE) && !is_end
                         && !discarding_reg && fits;

    assign rd_is_last = (LW'(rd_idx_reg) + LW'(1)) == drain_len_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_ACCEPT:
            begin
                if (start_drain)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (rd_issue && rd_is_last)
                    state_next = ST_ACCEPT;
            end
            default: state_next = ST_ACCEPT;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready = 1'b0;
        rd_issue = 1'b0;
        case (state_reg)
            ST_ACCEPT: in_ready = 1'b1;
            ST_DRAIN:  rd_issue = !rd_pend_reg && (!out_valid_reg || out_ready);
            default:   ;
        endcase
    end

    // frame memory
    always_ff @(posedge clk)
    begin
        if (store_byte)
            mem[len_reg[AW-1:0]] <= data_byte;
        if (rd_issue)
            rd_data_reg <= mem[rd_idx_reg];
    end

    // frame assembly and readout control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_ACCEPT;
            len_reg            <= '0;
            discarding_reg     <= 1'b0;
            frame_count_reg    <= 32'd0;
            oversize_count_reg <= 32'd0;
            drain_len_reg      <= '0;
            rd_idx_reg         <= '0;
            rd_pend_reg        <= 1'b0;
            rd_last_reg        <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_issue;
            if (rd_issue)
            begin
                rd_last_reg <= rd_is_last;
                rd_idx_reg  <= rd_is_last ? '0 : rd_idx_reg + AW'(1);
            end
            if (in_xfer)
            begin
                if (op_t'(op) == OP_FLUSH)
                begin
                    len_reg        <= '0;
                    discarding_reg <= 1'b0;
                end
                else if (is_end)
                begin
                    len_reg        <= '0;
                    discarding_reg <= 1'b0;
                    if (start_drain)
                    begin
                        frame_count_reg <= frame_count_reg + 32'd1;
                        drain_len_reg   <= len_reg;
                        rd_idx_reg      <= '0;
                    end
                end
                else if (!discarding_reg)
                begin
                    if (fits)
                        len_reg <= len_reg + LW'(1);
                    else
                    begin
                        len_reg            <= '0;
                        oversize_count_reg <= oversize_count_reg + 32'd1;
                        discarding_reg     <= 1'b1;
                    end
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (rd_pend_reg)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (rd_pend_reg)
        begin
            out_byte_reg     <= rd_data_reg;
            out_last_reg     <= rd_last_reg;
            out_frames_reg   <= frame_count_reg;
            out_oversize_reg <= oversize_count_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign frame_byte     = out_byte_reg;
    assign last_byte      = out_last_reg;
    assign frames_done    = out_frames_reg;
    assign oversize_drops = out_oversize_reg;

endmodule
